// File: hw/rtl/nth_weekday_of_month_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nth weekday of month block
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef NTH_WEEKDAY_OF_MONTH_DEFINES_SVH
`define NTH_WEEKDAY_OF_MONTH_DEFINES_SVH

// same-cycle implication
`define NTWOM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define NTWOM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/ntwom_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ntwom_pkg
// Types, codes and calendar tables shared by the nth weekday pipeline.
// ---------------------------------------------------------------------------
package ntwom_pkg;

  localparam logic [13:0] YearMax    = 14'd9999;
  localparam logic [3:0]  MonthJan   = 4'd1;
  localparam logic [3:0]  MonthFeb   = 4'd2;
  localparam logic [3:0]  MonthMar   = 4'd3;
  localparam logic [3:0]  MonthDec   = 4'd12;
  localparam logic [2:0]  WeekdayMax = 3'd6;

  // floor(y / 100) = (y * Div100Mul) >> Div100Shift for all 14-bit y
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned ProdW       = 27;

  typedef enum logic [2:0] {
    SelFirst  = 3'd0,
    SelSecond = 3'd1,
    SelThird  = 3'd2,
    SelFourth = 3'd3,
    SelTeenth = 3'd4,
    SelLast   = 3'd5
  } sel_e;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [2:0]  week_selector;
    logic [2:0]  weekday;
  } req_t;

  typedef struct packed {
    logic [4:0] day;
    logic       error;
  } resp_t;

  // after the year stage
  typedef struct packed {
    logic        err;
    logic [3:0]  month;
    logic [2:0]  sel;
    logic [2:0]  wd;
    logic        leap;
    logic [14:0] sum;
  } yr_t;

  // after the weekday stage
  typedef struct packed {
    logic       err;
    logic [2:0] sel;
    logic [2:0] d1;
    logic [4:0] ndays;
  } dow_t;

  // month offset plus one, for the first-of-month weekday sum
  function automatic logic [2:0] month_off1(input logic [3:0] m);
    logic [2:0] r;
    case (m)
      4'd1:    r = 3'd1;
      4'd2:    r = 3'd4;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd7;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:                  r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:               r = 5'd31;
    endcase
    return r;
  endfunction

  // 8 = 1 mod 7: fold octal digits, then one compare and subtract
  function automatic logic [2:0] mod7(input logic [14:0] v);
    logic [5:0] s;
    logic [3:0] f;
    s = {3'b0, v[2:0]} + {3'b0, v[5:3]} + {3'b0, v[8:6]}
      + {3'b0, v[11:9]} + {3'b0, v[14:12]};
    f = {1'b0, s[5:3]} + {1'b0, s[2:0]};
    if (f >= 4'd7) begin
      f = f - 4'd7;
    end
    return f[2:0];
  endfunction

endpackage

// File: hw/rtl/ntwom_year.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ntwom_year
// Two stages: range check and divide-by-100 product, then the Gregorian
// day-count sum and the leap flag.
// ---------------------------------------------------------------------------
module ntwom_year (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ntwom_pkg::req_t    req_i,
  output logic               valid_o,
  output ntwom_pkg::yr_t     yr_o
);

  logic                          a_valid_q;
  logic                          a_err_d, a_err_q;
  logic [13:0]                   a_yy_d, a_yy_q;
  logic [ntwom_pkg::ProdW-1:0]   a_prod_d, a_prod_q;
  logic [3:0]                    a_month_q;
  logic [2:0]                    a_sel_q, a_wd_q, a_off_q;

  logic [7:0]                    q100;
  logic [13:0]                   r100;
  ntwom_pkg::yr_t                b_d, b_q;
  logic                          b_valid_q;

  always_comb begin
    a_err_d = (req_i.year == 14'd0) || (req_i.year > ntwom_pkg::YearMax)
           || (req_i.month < ntwom_pkg::MonthJan) || (req_i.month > ntwom_pkg::MonthDec)
           || (req_i.week_selector > ntwom_pkg::SelLast)
           || (req_i.weekday > ntwom_pkg::WeekdayMax);
    a_yy_d   = (req_i.month < ntwom_pkg::MonthMar) ? req_i.year - 14'd1 : req_i.year;
    a_prod_d = {13'b0, a_yy_d} * {14'b0, ntwom_pkg::Div100Mul};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_err_q   <= a_err_d;
      a_yy_q    <= a_yy_d;
      a_prod_q  <= a_prod_d;
      a_month_q <= req_i.month;
      a_sel_q   <= req_i.week_selector;
      a_wd_q    <= req_i.weekday;
      a_off_q   <= ntwom_pkg::month_off1(req_i.month);
      b_q       <= b_d;
    end
  end

  // leap flag is for yy + 1, only read for February where yy = year - 1
  always_comb begin
    q100       = a_prod_q[ntwom_pkg::ProdW-1:ntwom_pkg::Div100Shift];
    r100       = a_yy_q - 14'({q100, 6'b0} + {q100, 5'b0} + {q100, 2'b0});
    b_d.err    = a_err_q;
    b_d.month  = a_month_q;
    b_d.sel    = a_sel_q;
    b_d.wd     = a_wd_q;
    b_d.leap   = (a_yy_q[1:0] == 2'd3) && ((r100 != 14'd99) || (q100[1:0] == 2'd3));
    b_d.sum    = {1'b0, a_yy_q} + {3'b0, a_yy_q[13:2]} - {7'b0, q100}
               + {9'b0, q100[7:2]} + {12'b0, a_off_q};
  end

  assign valid_o = b_valid_q;
  assign yr_o    = b_q;

endmodule

// File: hw/rtl/ntwom_dow.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ntwom_dow
// Weekday of the first of the month, first matching day and month length.
// ---------------------------------------------------------------------------
module ntwom_dow (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ntwom_pkg::yr_t    yr_i,
  output logic              valid_o,
  output ntwom_pkg::dow_t   dow_o
);

  logic [2:0]      fw;
  logic [3:0]      diff;
  ntwom_pkg::dow_t c_d, c_q;
  logic            c_valid_q;

  always_comb begin
    fw = ntwom_pkg::mod7(yr_i.sum);
    if (yr_i.wd >= fw) begin
      diff = {1'b0, yr_i.wd} - {1'b0, fw};
    end else begin
      diff = {1'b0, yr_i.wd} + 4'd7 - {1'b0, fw};
    end
    c_d.err   = yr_i.err;
    c_d.sel   = yr_i.sel;
    c_d.d1    = 3'(diff + 4'd1);
    c_d.ndays = ntwom_pkg::month_len(yr_i.month)
              + {4'b0, (yr_i.month == ntwom_pkg::MonthFeb) && yr_i.leap};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign valid_o = c_valid_q;
  assign dow_o   = c_q;

endmodule

// File: hw/rtl/ntwom_pick.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ntwom_pick
// Week selection and the output register.
// ---------------------------------------------------------------------------
`include "nth_weekday_of_month_defines.svh"

module ntwom_pick (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ntwom_pkg::dow_t   dow_i,
  output logic              valid_o,
  output ntwom_pkg::resp_t  resp_o
);

  logic [5:0]       d1w, day;
  ntwom_pkg::resp_t resp_d, resp_q;
  logic             valid_q;

  always_comb begin
    d1w = {3'b0, dow_i.d1};
    case (ntwom_pkg::sel_e'(dow_i.sel))
      ntwom_pkg::SelFirst:  day = d1w;
      ntwom_pkg::SelSecond: day = d1w + 6'd7;
      ntwom_pkg::SelThird:  day = d1w + 6'd14;
      ntwom_pkg::SelFourth: day = d1w + 6'd21;
      ntwom_pkg::SelTeenth: day = (d1w < 6'd6) ? d1w + 6'd14 : d1w + 6'd7;
      ntwom_pkg::SelLast:   day = (d1w + 6'd28 > {1'b0, dow_i.ndays}) ? d1w + 6'd21
                                                                     : d1w + 6'd28;
      default:              day = 6'd0;
    endcase
    resp_d.error = dow_i.err;
    resp_d.day   = dow_i.err ? 5'd0 : day[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      resp_q <= resp_d;
    end
  end

  assign valid_o = valid_q;
  assign resp_o  = resp_q;

  `NTWOM_ASSERT_NEXT(a_teenth_range,
    en_i && valid_i && !dow_i.err && (dow_i.sel == ntwom_pkg::SelTeenth),
    (resp_q.day >= 5'd13) && (resp_q.day <= 5'd19))
  `NTWOM_ASSERT_NEXT(a_last_range,
    en_i && valid_i && !dow_i.err && (dow_i.sel == ntwom_pkg::SelLast),
    (resp_q.day >= 5'd22) && (resp_q.day <= $past(dow_i.ndays)))
  `NTWOM_ASSERT_NOW(a_err_day_zero, valid_q && resp_q.error, resp_q.day == 5'd0)
  `NTWOM_ASSERT_NOW(a_ok_day_nonzero, valid_q && !resp_q.error, resp_q.day != 5'd0)

endmodule

// File: hw/rtl/nth_weekday_of_month.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nth_weekday_of_month
// Day of the month on which the nth (or teenth, or last) given weekday falls.
//
//   channel  handshake                payload
//   in       in_valid_i / in_ready_o  in_req_i   (year, month, selector, weekday)
//   out      out_valid_o / out_ready_i out_resp_o (day, error)
//
// One item per cycle while the output side does not stall; four register
// stages: year check, year sum, weekday and output.
// Reset clears the stage valid bits only.
// A stall on the output freezes every stage together; in_ready_o drops with it.
// ---------------------------------------------------------------------------
module nth_weekday_of_month (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ntwom_pkg::req_t   in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ntwom_pkg::resp_t  out_resp_o
);

  logic            en;
  logic            yr_valid, dow_valid;
  ntwom_pkg::yr_t  yr;
  ntwom_pkg::dow_t dow;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  ntwom_year u_year (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (yr_valid),
    .yr_o    (yr)
  );

  ntwom_dow u_dow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (yr_valid),
    .yr_i    (yr),
    .valid_o (dow_valid),
    .dow_o   (dow)
  );

  ntwom_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dow_valid),
    .dow_i   (dow),
    .valid_o (out_valid_o),
    .resp_o  (out_resp_o)
  );

endmodule
